@@ rtl/rtp_header_parser_unit_macros.svh @@
// ---------------------------------------------------------------------------
// RTP header parser assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_UNIT_MACROS_SVH
`define RTP_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhp: same-cycle check failed");
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhp: next-cycle check failed");
`else
`define RHP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rhp_pkg.sv @@
// ---------------------------------------------------------------------------
// RTP header parser package
// Status codes, header constants and the records passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_EXT_TRUNC = 3'd3;
    localparam logic [2:0] ST_HDR_LONG  = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    localparam logic [1:0]  RTP_VERSION   = 2'd2;
    localparam logic [15:0] FIXED_HDR_LEN = 16'd12;

    // one finished packet, as captured by the front end
    typedef struct packed {
        logic        too_long;
        logic [15:0] pkt_len;
        logic [7:0]  last_value;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [15:0] ext_words;
    } t_rec;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  payload_type;
        logic        marker;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [31:0] source_id;
        logic [3:0]  contrib_count;
        logic        has_extension;
        logic [18:0] header_length;
        logic [15:0] payload_length;
        logic [15:0] packet_length;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rhp_if.sv @@
// ---------------------------------------------------------------------------
// RTP header parser channels
// Byte input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface rhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  payload_type;
    logic        marker;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [3:0]  contrib_count;
    logic        has_extension;
    logic [18:0] header_length;
    logic [15:0] payload_length;
    logic [15:0] packet_length;

    modport source (
        output valid, output status, output payload_type, output marker,
        output sequence_res, output timestamp, output source_id, output contrib_count,
        output has_extension, output header_length, output payload_length,
        output packet_length, input ready
    );
    modport sink (
        input valid, input status, input payload_type, input marker,
        input sequence_res, input timestamp, input source_id, input contrib_count,
        input has_extension, input header_length, input payload_length,
        input packet_length, output ready
    );
endinterface

`default_nettype wire

@@ rtl/rtp_header_parser_unit.sv @@
// ---------------------------------------------------------------------------
// RTP header parser unit
// Usage:
//   i_in carries one packet byte per request, network order; last_byte marks
//   the final byte. o_out carries one result request per packet: status,
//   header fields and header, payload and packet lengths.
//   Throughput: one byte per cycle, sustained while i_in.ready is high,
//   including back-to-back packets of any length down to one byte.
//   Result path: once the last byte is taken, the record passes through the
//   record queue head, the two length evaluation stages and the output
//   register; a stalled o_out can hold it at any of these.
//   Stall: a stalled o_out holds its result; the back end fills up, then
//   the record queue (QUEUE_DEPTH plus one records), and only then does
//   i_in.ready drop. Until then bytes keep coming in while results wait.
//   Packets longer than MAX_LEN bytes stop counting and report too long.
//   Reset (synchronous, active low) empties the queue and pipeline and
//   restarts byte counting at the first byte of a new packet.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rtp_header_parser_unit_macros.svh"

module rtp_header_parser_unit #(
    parameter int unsigned MAX_LEN     = 65535,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rhp_in_if.sink      i_in,
    rhp_out_if.source   o_out
);

    logic           w_push_valid, w_push_ready;
    logic           w_pop_valid, w_pop_ready;
    rhp_pkg::t_rec  w_push_rec, w_pop_rec;

    rhp_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_rec   (w_push_rec),
        .i_push_ready (w_push_ready)
    );

    rhp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_rec   (w_push_rec),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_rec    (w_pop_rec),
        .i_pop_ready  (w_pop_ready)
    );

    rhp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop_valid),
        .i_rec   (w_pop_rec),
        .o_ready (w_pop_ready),
        .o_out   (o_out)
    );

    `RHP_ASSERT_IMPL(a_err_no_len, i_clk, i_rst_n, o_out.valid && o_out.status != rhp_pkg::ST_OK, o_out.header_length == '0 && o_out.payload_length == '0)
    `RHP_ASSERT_IMPL(a_short_no_hdr, i_clk, i_rst_n, o_out.valid && (o_out.status == rhp_pkg::ST_SHORT || o_out.status == rhp_pkg::ST_TOO_LONG), o_out.source_id == '0 && o_out.timestamp == '0 && o_out.contrib_count == '0)
    `RHP_ASSERT_IMPL(a_ok_fits, i_clk, i_rst_n, o_out.valid && o_out.status == rhp_pkg::ST_OK, 20'(o_out.header_length) + 20'(o_out.payload_length) <= 20'(o_out.packet_length))
    `RHP_ASSERT_IMPL(a_ok_min_hdr, i_clk, i_rst_n, o_out.valid && o_out.status == rhp_pkg::ST_OK, o_out.header_length >= 19'd12)

endmodule

`default_nettype wire

@@ rtl/rhp_front.sv @@
// ---------------------------------------------------------------------------
// RTP header parser front end
// Counts packet bytes, captures header fields, pushes one record per packet.
// ---------------------------------------------------------------------------
`default_nettype none

module rhp_front #(
    parameter int unsigned MAX_LEN = 65535
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    rhp_in_if.sink           i_in,
    output logic             o_push_valid,
    output rhp_pkg::t_rec    o_push_rec,
    input  wire              i_push_ready
);

    localparam logic [15:0] MAX_CNT = 16'(MAX_LEN);

    logic [15:0] r_count,    n_count;
    logic        r_too_long, n_too_long;
    logic [7:0]  r_hdr0,     n_hdr0;
    logic [7:0]  r_hdr1,     n_hdr1;
    logic [15:0] r_seq,      n_seq;
    logic [31:0] r_ts,       n_ts;
    logic [31:0] r_ssrc,     n_ssrc;
    logic [15:0] r_ext,      n_ext;

    logic        w_acc;
    logic [15:0] w_ext_pos;
    logic [7:0]  w_b;

    assign i_in.ready = i_push_ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_b        = i_in.byte_value;
    // extension length word sits two bytes past the CSRC list
    assign w_ext_pos  = {10'd0, r_hdr0[3:0], 2'b00} + 16'd14;

    always_comb begin
        n_count    = r_count;
        n_too_long = r_too_long;
        n_hdr0     = r_hdr0;
        n_hdr1     = r_hdr1;
        n_seq      = r_seq;
        n_ts       = r_ts;
        n_ssrc     = r_ssrc;
        n_ext      = r_ext;
        if (r_count >= MAX_CNT) begin
            n_too_long = 1'b1;
        end else begin
            n_count = r_count + 16'd1;
            if (r_count == 16'd0) begin
                n_hdr0 = w_b;
            end else if (r_count == 16'd1) begin
                n_hdr1 = w_b;
            end else if (r_count < 16'd4) begin
                n_seq = {r_seq[7:0], w_b};
            end else if (r_count < 16'd8) begin
                n_ts = {r_ts[23:0], w_b};
            end else if (r_count < 16'd12) begin
                n_ssrc = {r_ssrc[23:0], w_b};
            end
            if (r_count >= 16'd12 &&
                (r_count == w_ext_pos || r_count == w_ext_pos + 16'd1)) begin
                n_ext = {r_ext[7:0], w_b};
            end
        end
    end

    assign o_push_valid          = w_acc && i_in.last_byte;
    assign o_push_rec.too_long   = n_too_long;
    assign o_push_rec.pkt_len    = n_count;
    assign o_push_rec.last_value = w_b;
    assign o_push_rec.hdr0       = n_hdr0;
    assign o_push_rec.hdr1       = n_hdr1;
    assign o_push_rec.seq        = n_seq;
    assign o_push_rec.ts         = n_ts;
    assign o_push_rec.ssrc       = n_ssrc;
    assign o_push_rec.ext_words  = n_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_in.last_byte)) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_hdr0     <= '0;
            r_hdr1     <= '0;
            r_seq      <= '0;
            r_ts       <= '0;
            r_ssrc     <= '0;
            r_ext      <= '0;
        end else if (w_acc) begin
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_hdr0     <= n_hdr0;
            r_hdr1     <= n_hdr1;
            r_seq      <= n_seq;
            r_ts       <= n_ts;
            r_ssrc     <= n_ssrc;
            r_ext      <= n_ext;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rhp_fifo.sv @@
// ---------------------------------------------------------------------------
// RTP header parser record queue
// Short queue of packet records with a registered head entry.
// ---------------------------------------------------------------------------
`default_nettype none

module rhp_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    input  rhp_pkg::t_rec    i_push_rec,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output rhp_pkg::t_rec    o_pop_rec,
    input  wire              i_pop_ready
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rhp_pkg::t_rec r_mem [DEPTH];
    rhp_pkg::t_rec r_head;

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_head_v, n_head_v;

    logic w_push, w_load, w_mem_empty, w_from_mem, w_bypass, w_wr;

    assign w_mem_empty  = (r_cnt == '0);
    assign o_push_ready = (r_cnt != FULL_CNT);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_load       = !r_head_v || i_pop_ready;
    assign w_from_mem   = w_load && !w_mem_empty;
    assign w_bypass     = w_load && w_mem_empty && w_push;
    assign w_wr         = w_push && !w_bypass;

    assign o_pop_valid  = r_head_v;
    assign o_pop_rec    = r_head;

    always_comb begin
        n_wr     = r_wr;
        n_rd     = r_rd;
        n_cnt    = r_cnt;
        n_head_v = r_head_v;
        if (w_wr) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
        end
        if (w_from_mem) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
        end
        case ({w_wr, w_from_mem})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
        if (w_load) begin
            n_head_v = w_from_mem || w_bypass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
            r_head_v <= 1'b0;
        end else begin
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_cnt    <= n_cnt;
            r_head_v <= n_head_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push_rec;
        end
        if (w_from_mem) begin
            r_head <= r_mem[r_rd];
        end else if (w_bypass) begin
            r_head <= i_push_rec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rhp_back.sv @@
// ---------------------------------------------------------------------------
// RTP header parser back end
// Three-stage length and status evaluation with a registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module rhp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  rhp_pkg::t_rec    i_rec,
    output logic             o_ready,
    rhp_out_if.source        o_out
);

    logic              r_v1, r_v2, r_v3;
    rhp_pkg::t_rec     r_s1_rec, r_s2_rec;
    logic [2:0]        r_s1_status, r_s2_status;
    logic [18:0]       r_s1_hlen, r_s2_hlen;
    logic [15:0]       r_s2_diff;
    rhp_pkg::t_result  r_res;

    logic              w_rdy3, w_rdy2, w_rdy1;
    logic [2:0]        n_s1_status, n_s2_status;
    logic [18:0]       n_s1_hlen;
    logic [15:0]       n_s2_diff;
    rhp_pkg::t_result  n_res;

    logic [15:0]       w_base;
    logic [18:0]       w_ext_add;
    logic              w_hx;
    logic [15:0]       w_plen;
    logic              w_hdr_ok;

    assign w_rdy3  = !r_v3 || o_out.ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // stage 1: header length and the early status checks
    always_comb begin
        w_hx      = i_rec.hdr0[4];
        w_base    = {10'd0, i_rec.hdr0[3:0], 2'b00} + rhp_pkg::FIXED_HDR_LEN;
        w_ext_add = w_hx ? ({1'b0, i_rec.ext_words, 2'b00} + 19'd4) : '0;
        n_s1_hlen = {3'd0, w_base} + w_ext_add;
        if (i_rec.too_long) begin
            n_s1_status = rhp_pkg::ST_TOO_LONG;
        end else if (i_rec.pkt_len < rhp_pkg::FIXED_HDR_LEN) begin
            n_s1_status = rhp_pkg::ST_SHORT;
        end else if (i_rec.hdr0[7:6] != rhp_pkg::RTP_VERSION) begin
            n_s1_status = rhp_pkg::ST_BAD_VER;
        end else if (w_hx && (i_rec.pkt_len < w_base + 16'd4)) begin
            n_s1_status = rhp_pkg::ST_EXT_TRUNC;
        end else begin
            n_s1_status = rhp_pkg::ST_OK;
        end
    end

    // stage 2: header against packet length
    always_comb begin
        n_s2_status = r_s1_status;
        n_s2_diff   = '0;
        if (r_s1_status == rhp_pkg::ST_OK) begin
            if (r_s1_hlen > {3'd0, r_s1_rec.pkt_len}) begin
                n_s2_status = rhp_pkg::ST_HDR_LONG;
            end else begin
                n_s2_diff = r_s1_rec.pkt_len - r_s1_hlen[15:0];
            end
        end
    end

    // stage 3: padding removal and result assembly
    always_comb begin
        w_plen = r_s2_diff;
        if (r_s2_rec.hdr0[5] && r_s2_diff != '0 &&
            {8'd0, r_s2_rec.last_value} <= r_s2_diff) begin
            w_plen = r_s2_diff - {8'd0, r_s2_rec.last_value};
        end
        w_hdr_ok = !(r_s2_status == rhp_pkg::ST_SHORT || r_s2_status == rhp_pkg::ST_TOO_LONG);

        n_res                = '0;
        n_res.status         = r_s2_status;
        n_res.packet_length  = r_s2_rec.pkt_len;
        if (w_hdr_ok) begin
            n_res.payload_type  = r_s2_rec.hdr1[6:0];
            n_res.marker        = r_s2_rec.hdr1[7];
            n_res.sequence_res  = r_s2_rec.seq;
            n_res.timestamp     = r_s2_rec.ts;
            n_res.source_id     = r_s2_rec.ssrc;
            n_res.contrib_count = r_s2_rec.hdr0[3:0];
            n_res.has_extension = r_s2_rec.hdr0[4];
        end
        if (r_s2_status == rhp_pkg::ST_OK) begin
            n_res.header_length  = r_s2_hlen;
            n_res.payload_length = w_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_rec    <= i_rec;
            r_s1_status <= n_s1_status;
            r_s1_hlen   <= n_s1_hlen;
        end
        if (w_rdy2 && r_v1) begin
            r_s2_rec    <= r_s1_rec;
            r_s2_status <= n_s2_status;
            r_s2_hlen   <= r_s1_hlen;
            r_s2_diff   <= n_s2_diff;
        end
        if (w_rdy3 && r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.status         = r_res.status;
    assign o_out.payload_type   = r_res.payload_type;
    assign o_out.marker         = r_res.marker;
    assign o_out.sequence_res   = r_res.sequence_res;
    assign o_out.timestamp      = r_res.timestamp;
    assign o_out.source_id      = r_res.source_id;
    assign o_out.contrib_count  = r_res.contrib_count;
    assign o_out.has_extension  = r_res.has_extension;
    assign o_out.header_length  = r_res.header_length;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.packet_length  = r_res.packet_length;

endmodule

`default_nettype wire

@@ verif/rhp_checker.sv @@
// ---------------------------------------------------------------------------
// RTP header parser checker
// Watches the byte and result channels, keeps its own copy of the header
// capture state, predicts one result per packet and compares every result
// request with the oldest pending prediction.
// ---------------------------------------------------------------------------
module rhp_checker #(
    parameter int unsigned MAX_LEN = 65535
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rhp_in_if          i_in_mon,
    rhp_out_if         i_out_mon,
    output int         o_errors,
    output int         o_pending,
    output int         o_fires,
    output int         o_results,
    output logic [7:0] o_status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] byte_cnt;
    logic        overrun;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [15:0] seq_acc;
    logic [31:0] ts_acc;
    logic [31:0] ssrc_acc;
    logic [15:0] ext_acc;

    rhp_pkg::t_result hdr_expect_q[$];
    int          mismatch_cnt  = 0;
    int          pending_cnt   = 0;
    int          fire_cnt      = 0;
    int          result_cnt    = 0;
    logic [7:0]  seen_mask     = '0;

    assign o_errors      = mismatch_cnt;
    assign o_pending     = pending_cnt;
    assign o_fires       = fire_cnt;
    assign o_results     = result_cnt;
    assign o_status_seen = seen_mask;

    function automatic string fmt_result(input rhp_pkg::t_result r);
        return $sformatf(
            "st=%0d pt=%0d m=%0d seq=%h ts=%h ssrc=%h cc=%0d x=%0d hlen=%0d plen=%0d len=%0d",
            r.status, r.payload_type, r.marker, r.sequence_res, r.timestamp, r.source_id,
            r.contrib_count, r.has_extension, r.header_length, r.payload_length,
            r.packet_length);
    endfunction

    task automatic clear_capture();
        byte_cnt = '0;
        overrun  = 1'b0;
        hdr0     = '0;
        hdr1     = '0;
        seq_acc  = '0;
        ts_acc   = '0;
        ssrc_acc = '0;
        ext_acc  = '0;
    endtask

    // header capture per byte, result prediction on the last byte
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned ext_at;
        int unsigned len;
        int unsigned hlen;
        int unsigned plen;
        rhp_pkg::t_result r;
        pos = byte_cnt;
        if (pos >= MAX_LEN) begin
            overrun = 1'b1;
        end else begin
            byte_cnt = 16'(pos + 1);
            if (pos == 0) begin
                hdr0 = b;
            end else if (pos == 1) begin
                hdr1 = b;
            end else if (pos < 4) begin
                seq_acc = {seq_acc[7:0], b};
            end else if (pos < 8) begin
                ts_acc = {ts_acc[23:0], b};
            end else if (pos < rhp_pkg::FIXED_HDR_LEN) begin
                ssrc_acc = {ssrc_acc[23:0], b};
            end
            ext_at = rhp_pkg::FIXED_HDR_LEN + 4 * hdr0[3:0] + 2;
            if (pos >= rhp_pkg::FIXED_HDR_LEN && (pos == ext_at || pos == ext_at + 1)) begin
                ext_acc = {ext_acc[7:0], b};
            end
        end
        if (last) begin
            r    = '0;
            len  = byte_cnt;
            hlen = 0;
            plen = 0;
            if (overrun) begin
                r.status = rhp_pkg::ST_TOO_LONG;
            end else if (len < rhp_pkg::FIXED_HDR_LEN) begin
                r.status = rhp_pkg::ST_SHORT;
            end else begin
                hlen = rhp_pkg::FIXED_HDR_LEN + 4 * hdr0[3:0];
                if (hdr0[7:6] != rhp_pkg::RTP_VERSION) begin
                    r.status = rhp_pkg::ST_BAD_VER;
                end else if (hdr0[4] && len < hlen + 4) begin
                    r.status = rhp_pkg::ST_EXT_TRUNC;
                end else begin
                    if (hdr0[4]) begin
                        hlen = hlen + 4 + 4 * ext_acc;
                    end
                    if (hlen > len) begin
                        r.status = rhp_pkg::ST_HDR_LONG;
                    end else begin
                        r.status = rhp_pkg::ST_OK;
                        plen = len - hlen;
                        if (hdr0[5] && plen > 0 && b <= plen) begin
                            plen = plen - b;
                        end
                    end
                end
                if (r.status != rhp_pkg::ST_OK) begin
                    hlen = 0;
                    plen = 0;
                end
                r.payload_type  = hdr1[6:0];
                r.marker        = hdr1[7];
                r.sequence_res  = seq_acc;
                r.timestamp     = ts_acc;
                r.source_id     = ssrc_acc;
                r.contrib_count = hdr0[3:0];
                r.has_extension = hdr0[4];
            end
            r.header_length  = 19'(hlen);
            r.payload_length = 16'(plen);
            r.packet_length  = 16'(len);
            hdr_expect_q.push_back(r);
            clear_capture();
        end
    endtask

    always @(posedge i_clk) begin : p_monitor
        rhp_pkg::t_result got;
        rhp_pkg::t_result want;
        if (!i_rst_n) begin
            clear_capture();
            hdr_expect_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                fire_cnt++;
                parse_byte(i_in_mon.byte_value, i_in_mon.last_byte);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                fire_cnt++;
                result_cnt++;
                got.status         = i_out_mon.status;
                got.payload_type   = i_out_mon.payload_type;
                got.marker         = i_out_mon.marker;
                got.sequence_res   = i_out_mon.sequence_res;
                got.timestamp      = i_out_mon.timestamp;
                got.source_id      = i_out_mon.source_id;
                got.contrib_count  = i_out_mon.contrib_count;
                got.has_extension  = i_out_mon.has_extension;
                got.header_length  = i_out_mon.header_length;
                got.payload_length = i_out_mon.payload_length;
                got.packet_length  = i_out_mon.packet_length;
                if (got.status <= rhp_pkg::ST_TOO_LONG) begin
                    seen_mask = seen_mask | (8'd1 << got.status);
                end
                if (hdr_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("checker: result with no packet pending: %s",
                                 fmt_result(got));
                    end
                end else begin
                    want = hdr_expect_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("checker: mismatch on result %0d", result_cnt);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                    end
                end
            end
        end
        pending_cnt = hdr_expect_q.size();
    end

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// RTP header parser testbench
// Feeds directed and random RTP packets byte by byte under three idle
// profiles and one long output hold-off. The checker predicts and
// compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN  = 65535;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int HOLD_CYCLES       = 600;
    localparam int DRAIN_CYCLES      = 20;
    localparam int PHASE_BYTES       = 200;

    logic       i_clk;
    logic       i_rst_n;

    rhp_in_if   in_ch ();
    rhp_out_if  out_ch ();

    int         errors;
    int         pending;
    int         fires;
    int         results;
    logic [7:0] status_seen;

    int         src_idle_pct = 0;
    int         dst_idle_pct = 0;
    int         hold_reqs    = 0;
    int         bytes_sent   = 0;
    int         pkts_sent    = 0;
    logic [7:0] pkt[$];

    rtp_header_parser_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rhp_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_fires       (fires),
        .o_results     (results),
        .o_status_seen (status_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random ready, or a long hold-off when requested
    initial begin : p_sink
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    initial begin : p_watchdog
        int idle_cycles;
        int last_fires;
        idle_cycles = 0;
        last_fires  = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if (fires != last_fires) begin
                last_fires  = fires;
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic took;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= last;
        do begin
            @(negedge i_clk) took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        pkts_sent++;
    endtask

    task automatic trim_pkt(input int n);
        while (pkt.size() > n) begin
            pkt.pop_back();
        end
    endtask

    task automatic set_last(input logic [7:0] b);
        pkt[pkt.size() - 1] = b;
    endtask

    // fixed header, CSRC list, optional extension and payload, random content
    task automatic build_rtp(input logic [1:0] ver, input logic pad, input logic ext,
                             input logic [3:0] cc, input int ext_len,
                             input logic [15:0] ext_word, input int pay_len);
        pkt.delete();
        pkt.push_back({ver, pad, ext, cc});
        repeat (11 + 4 * cc) pkt.push_back(rnd_byte());
        if (ext) begin
            pkt.push_back(rnd_byte());
            pkt.push_back(rnd_byte());
            pkt.push_back(ext_word[15:8]);
            pkt.push_back(ext_word[7:0]);
            repeat (4 * ext_len) pkt.push_back(rnd_byte());
        end
        repeat (pay_len) pkt.push_back(rnd_byte());
    endtask

    task automatic run_directed();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b0, 4'd0, 0, 16'd0, 0);
        trim_pkt(1);
        send_pkt();
        pkt.delete();
        repeat (11) pkt.push_back(8'hFF);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b0, 4'd0, 0, 16'd0, 0);
        for (int i = 1; i < 12; i++) pkt[i] = 8'hFF;
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b0, 4'd0, 0, 16'd0, 0);
        for (int i = 1; i < 12; i++) pkt[i] = 8'h00;
        send_pkt();
        for (int v = 0; v < 4; v++) begin
            if (2'(v) != rhp_pkg::RTP_VERSION) begin
                build_rtp(2'(v), 1'b1, 1'b1, 4'hF, 1, 16'd1, 3);
                send_pkt();
            end
        end
        // extension word cut off, exact fit, and oversized extension length
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b1, 4'd0, 0, 16'd0, 0);
        trim_pkt(15);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b1, 4'd0, 0, 16'd0, 0);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b1, 4'd0, 0, 16'hFFFF, 8);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b0, 1'b0, 4'hF, 0, 16'd0, 0);
        trim_pkt(12);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b1, 4'hF, 2, 16'd2, 10);
        set_last(8'd4);
        send_pkt();
        // padding: fits, consumes all, one too many, far too many, no payload
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b0, 4'd0, 0, 16'd0, 5);
        set_last(8'd3);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b0, 4'd0, 0, 16'd0, 5);
        set_last(8'd5);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b0, 4'd0, 0, 16'd0, 5);
        set_last(8'd6);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b0, 4'd0, 0, 16'd0, 5);
        set_last(8'hFF);
        send_pkt();
        build_rtp(rhp_pkg::RTP_VERSION, 1'b1, 1'b0, 4'd0, 0, 16'd0, 0);
        set_last(8'd0);
        send_pkt();
    endtask

    task automatic make_random_pkt();
        int         kind;
        int         pay;
        int         ext_len;
        logic       pad;
        logic       ext;
        logic [3:0] cc;
        kind = $urandom_range(99);
        if (kind < 15) begin
            pkt.delete();
            repeat ($urandom_range(40, 1)) pkt.push_back(rnd_byte());
        end else begin
            pad     = ($urandom_range(99) < 35);
            ext     = ($urandom_range(99) < 35);
            cc      = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
            ext_len = $urandom_range(3);
            pay     = ($urandom_range(9) == 0) ? 0 : $urandom_range(24);
            build_rtp(rhp_pkg::RTP_VERSION, pad, ext, cc, ext_len, 16'(ext_len), pay);
            if (pad && pay > 0) begin
                if ($urandom_range(3) == 0) begin
                    set_last(rnd_byte());
                end else begin
                    set_last(8'($urandom_range(pay + 1)));
                end
            end
            if (kind < 35) begin
                case ($urandom_range(2))
                    0: begin
                        trim_pkt($urandom_range(pkt.size(), 1));
                    end
                    1: begin
                        pkt[0] = {2'($urandom_range(3)), pkt[0][5:0]};
                    end
                    default: begin
                        if (ext) begin
                            pkt[14 + 4 * cc] = rnd_byte();
                            pkt[15 + 4 * cc] = rnd_byte();
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic run_random(input int n_bytes, input logic with_hold);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if (with_hold && bytes_sent - start >= n_bytes / 2) begin
                hold_reqs++;
                with_hold = 1'b0;
            end
            make_random_pkt();
            send_pkt();
        end
    endtask

    initial begin : p_stim
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.byte_value <= '0;
        in_ch.last_byte  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 21;
        dst_idle_pct = 48;
        run_directed();
        run_random(PHASE_BYTES, 1'b1);

        src_idle_pct = 48;
        dst_idle_pct = 21;
        run_random(PHASE_BYTES, 1'b0);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(PHASE_BYTES, 1'b0);
        in_ch.valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("tb: %0d packets in %0d bytes driven, %0d results checked",
                 pkts_sent, bytes_sent, results);
        $display("tb: status codes returned, one bit per code from ok upward: %b",
                 status_seen[5:0]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d bad results", errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
